>>> hdl/s8b_pkg.sv
// Shared types, constants and selector tables of the Simple-8b word decoder.
package s8b_pkg;

	localparam int WORD_BITS  = 64;
	localparam int SEL_BITS   = 4;
	localparam int VAL_BITS   = 60;
	localparam int REP_BITS   = 8;
	localparam int WIDTH_BITS = 6;

	typedef logic [SEL_BITS-1:0]   sel_t;
	typedef logic [VAL_BITS-1:0]   val_t;
	typedef logic [REP_BITS-1:0]   rep_t;
	typedef logic [WIDTH_BITS-1:0] width_t;

	// Controls from the sequencer to the shared unpack unit.
	typedef struct packed {
		logic   load;
		logic   step;
		width_t width;
	} unp_ctrl_t;

	// Number of values carried by a word with this selector.
	function automatic rep_t sel_count(input sel_t sel);
		rep_t n;
		unique case (sel)
			4'd0:  n = 8'd240;
			4'd1:  n = 8'd120;
			4'd2:  n = 8'd60;
			4'd3:  n = 8'd30;
			4'd4:  n = 8'd20;
			4'd5:  n = 8'd15;
			4'd6:  n = 8'd12;
			4'd7:  n = 8'd10;
			4'd8:  n = 8'd8;
			4'd9:  n = 8'd7;
			4'd10: n = 8'd6;
			4'd11: n = 8'd5;
			4'd12: n = 8'd4;
			4'd13: n = 8'd3;
			4'd14: n = 8'd2;
			default: n = 8'd1;
		endcase
		return n;
	endfunction

	// Bit width of each value for this selector; zero marks a zero run.
	function automatic width_t sel_width(input sel_t sel);
		width_t w;
		unique case (sel)
			4'd0:  w = 6'd0;
			4'd1:  w = 6'd0;
			4'd2:  w = 6'd1;
			4'd3:  w = 6'd2;
			4'd4:  w = 6'd3;
			4'd5:  w = 6'd4;
			4'd6:  w = 6'd5;
			4'd7:  w = 6'd6;
			4'd8:  w = 6'd7;
			4'd9:  w = 6'd8;
			4'd10: w = 6'd10;
			4'd11: w = 6'd12;
			4'd12: w = 6'd15;
			4'd13: w = 6'd20;
			4'd14: w = 6'd30;
			default: w = 6'd60;
		endcase
		return w;
	endfunction

	// Mask of the low w bits of a value.
	function automatic val_t val_mask(input width_t w);
		return ~({VAL_BITS{1'b1}} << w);
	endfunction

endpackage

>>> hdl/simple8b_word_decoder_top.sv
// Simple-8b word decoder: stream in one 64-bit word, stream out its decoded values.
// A word is accepted in idle; a setup state then works out how many values remain.
// The word then passes into the run state, which registers one result per cycle while the output is not stalled.
// A zero run gives a single result; a word with nothing left gives none.
// The rate is set by the single shared shift unit, which yields one value per cycle unless the output stalls.
// arst_n clears the sequencer, the output valid, the value count and the total register.
module simple8b_word_decoder_top #(
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] packed_word
	input  logic        s_tuser,   // [0] stream_start
	// decoded values
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [59:0] value, [67:60] repeat_res, [71:68] zero
	output logic        m_tlast    // last_of_word
);
	import s8b_pkg::*;

	localparam int TW = (COUNT_BITS < 32) ? COUNT_BITS : 32;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	logic [1:0]            state_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [COUNT_BITS-1:0] emitted_q;
	sel_t                  sel_q;
	rep_t                  take_q;
	rep_t                  cnt_q;
	logic                  zero_q;

	logic                  out_valid_q;
	val_t                  out_val_q;
	rep_t                  out_rep_q;
	logic                  out_last_q;

	logic                  cfg_wr;
	logic                  in_acc;
	logic [COUNT_BITS-1:0] diff;
	logic                  any_left;
	rep_t                  n_sel;
	rep_t                  take;
	logic                  out_free;
	logic                  run_load;
	unp_ctrl_t             unp_ctrl;
	val_t                  unp_value;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && !paddr[2];
	assign prdata   = paddr[2] ? 32'd0 : 32'(total_q);
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_wr) begin
			total_q <= COUNT_BITS'(pwdata[TW-1:0]);
		end
	end

	// Values still allowed by the configured total, and the number this word gives.
	assign diff     = total_q - emitted_q;
	assign any_left = emitted_q < total_q;
	assign n_sel    = sel_count(sel_q);
	assign take     = (diff < COUNT_BITS'(n_sel)) ? diff[REP_BITS-1:0] : n_sel;

	assign out_free = !out_valid_q || m_tready;
	assign run_load = (state_q == ST_RUN) && out_free;

	assign unp_ctrl.load  = in_acc;
	assign unp_ctrl.step  = run_load;
	assign unp_ctrl.width = sel_width(s_tdata[SEL_BITS-1:0]);

	s8b_unpack u_unpack (
		.clk     (clk),
		.ctrl    (unp_ctrl),
		.payload (s_tdata[WORD_BITS-1:SEL_BITS]),
		.value   (unp_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			emitted_q <= '0;
			cnt_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SETUP;
						if (s_tuser) begin
							emitted_q <= '0;
						end
					end
				end
				ST_SETUP: begin
					if (any_left && take != '0) begin
						state_q <= ST_RUN;
						cnt_q   <= (sel_width(sel_q) == '0) ? rep_t'(1) : take;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RUN: begin
					if (out_free) begin
						cnt_q <= cnt_q - rep_t'(1);
						if (cnt_q == rep_t'(1)) begin
							state_q   <= ST_IDLE;
							emitted_q <= emitted_q + COUNT_BITS'(take_q);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sel_q <= s_tdata[SEL_BITS-1:0];
		end
		if (state_q == ST_SETUP) begin
			take_q <= take;
			zero_q <= (sel_width(sel_q) == '0);
		end
	end

	// Output register: holds one result while the next is being prepared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (run_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run_load) begin
			out_val_q  <= unp_value;
			out_rep_q  <= zero_q ? take_q : rep_t'(1);
			out_last_q <= (cnt_q == rep_t'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_rep_q, out_val_q};
	assign m_tlast  = out_last_q;

	a_run_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (cnt_q != '0))
		else $error("run state entered with no results left");

	a_accept_to_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_SETUP))
		else $error("accepted word did not go to setup");

	a_rep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[67:60] != '0))
		else $error("result with zero repeat count");

	a_run_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[67:60] != rep_t'(1)) |-> (m_tdata[59:0] == '0 && m_tlast))
		else $error("repeated result is not a single zero run");

endmodule

>>> hdl/s8b_unpack.sv
// Shared shift unit that peels one packed value per step off the word.
module s8b_unpack (
	input  logic              clk,
	input  s8b_pkg::unp_ctrl_t ctrl,
	input  s8b_pkg::val_t     payload,
	output s8b_pkg::val_t     value
);
	import s8b_pkg::*;

	val_t   shreg_q;
	width_t width_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			shreg_q <= payload;
			width_q <= ctrl.width;
		end else if (ctrl.step) begin
			shreg_q <= shreg_q >> width_q;
		end
	end

	assign value = shreg_q & val_mask(width_q);

endmodule

>>> tb/tb_simple8b_word_decoder_top.sv
// Self-checking testbench for the Simple-8b word decoder: directed and random words, APB setup.
`timescale 1ns / 100ps

module tb_simple8b_word_decoder_top;
	import s8b_pkg::*;

	localparam int          CYCLE_LIMIT   = 2_000_000;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          RANDOM_WORDS  = 180;
	localparam logic [2:0]  ADDR_TOTAL    = 3'd0;
	localparam sel_t        SEL_RUN240    = 4'd0;
	localparam sel_t        SEL_RUN120    = 4'd1;
	localparam sel_t        SEL_BIT1      = 4'd2;
	localparam sel_t        SEL_BIT2      = 4'd3;
	localparam sel_t        SEL_BIT30     = 4'd14;
	localparam sel_t        SEL_BIT60     = 4'd15;

	// Values per word and bits per value, indexed by selector.
	localparam int unsigned VALS_PER_SEL[16] =
		'{240, 120, 60, 30, 20, 15, 12, 10, 8, 7, 6, 5, 4, 3, 2, 1};
	localparam int unsigned BITS_PER_SEL[16] =
		'{0, 0, 1, 2, 3, 4, 5, 6, 7, 8, 10, 12, 15, 20, 30, 60};

	typedef struct {
		val_t value;
		rep_t reps;
		logic last;
	} dec_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // [63:0] packed_word
	logic        s_tuser;   // [0] stream_start
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // [59:0] value, [67:60] repeat_res, [71:68] zero
	logic        m_tlast;   // last_of_word

	dec_result_t pending_values[$];
	logic [31:0] total_cfg;
	logic [31:0] count_done;
	int          error_count;
	int          cycle_count;
	int          sink_wait;
	bit          idle_on;

	simple8b_word_decoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_simple8b_word_decoder_top failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (error_count < 40)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int draw_wait();
		return idle_on ? int'($urandom_range(0, 15)) : 0;
	endfunction

	// Works out the values one accepted word decodes to and queues them.
	function automatic int decode_word(input logic [63:0] word, input logic start);
		int unsigned n;
		int unsigned wd;
		int unsigned take;
		logic [31:0] remaining;
		logic [63:0] vmask;
		dec_result_t r;
		n  = VALS_PER_SEL[word[3:0]];
		wd = BITS_PER_SEL[word[3:0]];
		if (start)
			count_done = '0;
		remaining = (count_done < total_cfg) ? total_cfg - count_done : 32'd0;
		if (remaining == 0)
			return 0;
		take = (remaining < n) ? remaining : n;
		if (wd == 0) begin
			r.value = '0;
			r.reps  = rep_t'(take);
			r.last  = 1'b1;
			pending_values = {pending_values, r};
		end else begin
			vmask = (64'd1 << wd) - 64'd1;
			for (int unsigned j = 0; j < take; j++) begin
				r.value = val_t'((word >> (4 + j * wd)) & vmask);
				r.reps  = rep_t'(1);
				r.last  = (j + 1 == take);
				pending_values = {pending_values, r};
			end
		end
		count_done = count_done + take;
		return take;
	endfunction

	// Output side: random stalls on m_tready, drawn after each accepted result.
	initial begin
		m_tready  = 1'b0;
		sink_wait = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready)
				sink_wait = draw_wait();
			@(negedge clk);
			if (sink_wait > 0) begin
				m_tready <= 1'b0;
				sink_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		dec_result_t e;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_values.size() == 0) begin
				report_mismatch($sformatf("unexpected word value=%h", m_tdata[59:0]));
			end else begin
				e = pending_values.pop_front();
				if (m_tdata[59:0] !== e.value)
					report_mismatch($sformatf("value %h, want %h", m_tdata[59:0], e.value));
				if (m_tdata[67:60] !== e.reps)
					report_mismatch($sformatf("repeat %0d, want %0d", m_tdata[67:60], e.reps));
				if (m_tlast !== e.last)
					report_mismatch($sformatf("last %b, want %b", m_tlast, e.last));
			end
		end
	end

	// Called at a falling edge; returns there after the word is taken.
	task automatic send_word(input logic [63:0] word, input logic start, output int produced);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		produced = decode_word(word, start);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_values.size() != 0)
			@(negedge clk);
		// A word that decodes to nothing may still be in flight.
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_total(input logic [31:0] tot);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_TOTAL;
		pwdata  <= tot;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		total_cfg = tot;
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== tot)
			report_mismatch($sformatf("total_values read %h, want %h", prdata, tot));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// With the total at zero every word is dropped.
	task automatic test_zero_total();
		int n;
		set_total(32'd0);
		send_word({60'hFFF_FFFF_FFFF_FFFF, SEL_BIT1}, 1'b1, n);
		send_word({60'h0, SEL_RUN240}, 1'b0, n);
		send_word({$urandom, $urandom}, 1'b1, n);
	endtask

	task automatic test_each_selector();
		int n;
		set_total(32'hFFFF_FFFF);
		for (int s = 0; s < 16; s++)
			send_word({60'hFFF_FFFF_FFFF_FFFF, sel_t'(s)}, s == 0, n);
		send_word({60'h0, SEL_BIT60}, 1'b0, n);
		send_word({60'h555_5555_5555_5555, SEL_BIT1}, 1'b0, n);
		send_word({60'hAAA_AAAA_AAAA_AAAA, SEL_BIT30}, 1'b0, n);
	endtask

	task automatic test_total_limits();
		int n;
		// A zero run crossing the total is cut short, then nothing is left.
		set_total(32'd5);
		send_word({60'h0, SEL_RUN240}, 1'b1, n);
		send_word({60'h123_4567_89AB_CDEF, SEL_BIT2}, 1'b0, n);
		// The total is reached in the middle of a packed word.
		set_total(32'd7);
		send_word({60'hFED_CBA9_8765_4321, SEL_BIT1}, 1'b1, n);
		// Count beyond a lowered total gives nothing until a new stream starts.
		set_total(32'd100);
		send_word({$urandom, 28'($urandom), SEL_RUN120}, 1'b0, n);
		set_total(32'd30);
		send_word({60'hFFF_FFFF_FFFF_FFFF, SEL_BIT2}, 1'b0, n);
		send_word({60'h0, SEL_RUN120}, 1'b1, n);
		set_total(32'd1);
		send_word({60'h8000_0000_0000_001, SEL_BIT60}, 1'b1, n);
	endtask

	task automatic test_random_streams();
		int sent_words;
		int phase;
		int n;
		logic [31:0] tot;
		logic [63:0] word;
		logic start;
		sent_words = 0;
		phase = 0;
		while (sent_words < RANDOM_WORDS) begin
			case (phase % 5)
				0: tot = $urandom_range(1, 300);
				1: tot = $urandom;
				2: tot = 32'hFFFF_FFFF;
				3: tot = $urandom_range(1, 40);
				default: tot = (phase % 10 == 4) ? 32'd0 : $urandom_range(100, 2000);
			endcase
			idle_on = (phase % 4 != 3);
			set_total(tot);
			for (int i = 0; i < 20; i++) begin
				word = {$urandom, $urandom};
				if ($urandom_range(0, 3) == 0)
					word[3:0] = sel_t'($urandom_range(SEL_RUN240, SEL_RUN120));
				start = (i == 0) || ($urandom_range(0, 5) == 0);
				send_word(word, start, n);
				sent_words++;
			end
			phase++;
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		total_cfg   = '0;
		count_done  = '0;
		error_count = 0;
		cycle_count = 0;
		idle_on     = 1'b1;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_zero_total();
		test_each_selector();
		test_total_limits();
		test_random_streams();

		wait_idle();
		repeat (20) @(negedge clk);
		if (error_count == 0) begin
			$display("tb_simple8b_word_decoder_top passed");
		end else begin
			$display("tb_simple8b_word_decoder_top failed");
		end
		$finish;
	end

endmodule

>>> simple8b_word_decoder_top.f
hdl/s8b_pkg.sv
hdl/s8b_unpack.sv
hdl/simple8b_word_decoder_top.sv
tb/tb_simple8b_word_decoder_top.sv
